// ===== sv/wrgd_pkg.sv =====
// ----------------------------------------------------------------------------
// wrgd_pkg: shared types and constants for the wrist raise gesture detector
// Digit and accumulator widths of the shared multiply-accumulate unit, the
// configuration register map and its reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package wrgd_pkg;

  // Multiplier digit; covers the widest sample difference magnitude
  localparam int DIG_W   = 18;
  localparam int PROD_W  = 2 * DIG_W;
  // Two-digit quantities: squared lengths, dot product, squared cosine limit
  localparam int WIDE_W  = 2 * DIG_W;
  // Four-digit product of the two squared lengths
  localparam int P_W     = 4 * DIG_W;
  // Accumulator wide enough for 2^30 * dot^2 - L^2 * la^2 * lb^2, signed
  localparam int ACC_W   = 100;
  localparam int SH_W    = 7;
  // Q0.15 cosine squared gives Q0.30, hence this extra shift on dot^2
  localparam int TILT_SH = 30;

  // Stream widths
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 8;

  // Configuration port
  localparam int ADDR_W     = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_MOVE_THR   = 3'd0,
    REG_QUIET_THR  = 3'd1,
    REG_QUIET_CNT  = 3'd2,
    REG_MOVE_TMO   = 3'd3,
    REG_COS_LIMIT  = 3'd4,
    REG_MIN_LEN    = 3'd5
  } reg_idx_e;

  localparam logic [15:0] RST_MOVE_THR  = 16'd1966;
  localparam logic [15:0] RST_QUIET_THR = 16'd819;
  localparam logic [7:0]  RST_QUIET_CNT = 8'd3;
  localparam logic [7:0]  RST_MOVE_TMO  = 8'd20;
  localparam logic [14:0] RST_COS_LIMIT = 15'd30791;
  localparam logic [15:0] RST_MIN_LEN   = 16'd164;

  typedef struct packed {
    logic [15:0] move_thr;
    logic [15:0] quiet_thr;
    logic [7:0]  quiet_cnt;
    logic [7:0]  move_tmo;
    logic [14:0] cos_limit;
    logic [15:0] min_len;
  } cfg_t;

  // One step of the shared multiply-accumulate unit
  typedef struct packed {
    logic            en;     // update the accumulator
    logic            clr;    // start from zero
    logic            sub;    // subtract the product
    logic [SH_W-1:0] shift;  // left shift of the product
  } mac_op_t;

endpackage

`default_nettype wire

// ===== sv/wrgd_regs.sv =====
// ----------------------------------------------------------------------------
// wrgd_regs: configuration register file
// APB-style port; a register is written on the access phase of a write.
// ----------------------------------------------------------------------------
`default_nettype none

module wrgd_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wrgd_pkg::ADDR_W-1:0]     paddr,
  input  logic [wrgd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [wrgd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output wrgd_pkg::cfg_t                 cfg_o
);
  import wrgd_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_MOVE_THR:  cfg_d.move_thr  = pwdata[15:0];
        REG_QUIET_THR: cfg_d.quiet_thr = pwdata[15:0];
        REG_QUIET_CNT: cfg_d.quiet_cnt = pwdata[7:0];
        REG_MOVE_TMO:  cfg_d.move_tmo  = pwdata[7:0];
        REG_COS_LIMIT: cfg_d.cos_limit = pwdata[14:0];
        REG_MIN_LEN:   cfg_d.min_len   = pwdata[15:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_MOVE_THR:  prdata = CFG_DATA_W'(cfg_q.move_thr);
      REG_QUIET_THR: prdata = CFG_DATA_W'(cfg_q.quiet_thr);
      REG_QUIET_CNT: prdata = CFG_DATA_W'(cfg_q.quiet_cnt);
      REG_MOVE_TMO:  prdata = CFG_DATA_W'(cfg_q.move_tmo);
      REG_COS_LIMIT: prdata = CFG_DATA_W'(cfg_q.cos_limit);
      REG_MIN_LEN:   prdata = CFG_DATA_W'(cfg_q.min_len);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.move_thr  <= RST_MOVE_THR;
      cfg_q.quiet_thr <= RST_QUIET_THR;
      cfg_q.quiet_cnt <= RST_QUIET_CNT;
      cfg_q.move_tmo  <= RST_MOVE_TMO;
      cfg_q.cos_limit <= RST_COS_LIMIT;
      cfg_q.min_len   <= RST_MIN_LEN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/wrgd_mac.sv =====
// ----------------------------------------------------------------------------
// wrgd_mac: shared multiply-accumulate unit
// One digit-by-digit product per enabled cycle, shifted into place and added to or
// subtracted from a wide two's complement accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module wrgd_mac (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wrgd_pkg::mac_op_t          op_i,
  input  logic [wrgd_pkg::DIG_W-1:0] a_i,
  input  logic [wrgd_pkg::DIG_W-1:0] b_i,
  output logic [wrgd_pkg::ACC_W-1:0] acc_o
);
  import wrgd_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  term;
  logic [ACC_W-1:0]  base;
  logic [ACC_W-1:0]  acc_d, acc_q;

  // Product, alignment and accumulate (modulo 2^ACC_W)
  assign prod  = PROD_W'(a_i) * PROD_W'(b_i);
  assign term  = ACC_W'(prod) << op_i.shift;
  assign base  = op_i.clr ? '0 : acc_q;
  assign acc_d = op_i.sub ? (base - term) : (base + term);
  assign acc_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (op_i.en) begin
      acc_q <= acc_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/wrist_raise_gesture_detector_core.sv =====
// ----------------------------------------------------------------------------
// wrist_raise_gesture_detector_core: wrist raise gesture detector
// Tracks motion between accelerometer samples and tests the tilt from the
// rest orientation with exact squared comparisons on a shared MAC unit.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  s_axis    | in        | tdata: watching, accel_x, accel_y, accel_z
//  m_axis    | out       | tdata: raised, in_motion
//  apb       | in/out    | six configuration registers at 4*index
//
//  An idle or reference sample: result valid the cycle after the accept edge.
//  Ordinary sample: three squared differences and one threshold term go
//  through the MAC, then a decision state, before the result is valid.
//  A motion end with tilt test: the result waits in addition for the 28
//  products of the tilt comparison on the single multiplier.
//  One sample at a time: s_axis_tready is low until the result is taken.
//  Asynchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module wrist_raise_gesture_detector_core #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COUNT_WIDTH  = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tdata: [0] watching, [16:1] accel_x, [32:17] accel_y, [48:33] accel_z
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [wrgd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tdata: [0] raised, [1] in_motion
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [wrgd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wrgd_pkg::ADDR_W-1:0]      paddr,
  input  logic [wrgd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [wrgd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import wrgd_pkg::*;

  // Only 16 bits reach the block; above 16 the sign bit is never set
  localparam int SW_EFF = (SAMPLE_WIDTH > 16) ? 17 : SAMPLE_WIDTH;
  localparam int NXT_W  = (COUNT_WIDTH + 1 > 9) ? COUNT_WIDTH + 1 : 9;

  typedef enum logic [5:0] {
    S_IDLE, S_D0, S_D1, S_D2, S_DT, S_DEC,
    S_LA0, S_LA1, S_LA2, S_LAM,
    S_LB0, S_LB1, S_LB2, S_LBM,
    S_DT0, S_DT1, S_DT2, S_MM,
    S_P00, S_P01, S_P10, S_P11,
    S_Q00, S_Q01, S_Q10, S_Q11,
    S_S00, S_S01, S_S10, S_S11, S_S20, S_S21, S_S30, S_S31,
    S_FIN, S_OUT
  } state_e;

  cfg_t              cfg;
  mac_op_t           mac_op;
  logic [DIG_W-1:0]  mac_a, mac_b;
  logic [ACC_W-1:0]  acc;

  state_e            state_q, state_d;
  logic              have_ref_q, have_ref_d;
  logic              motion_q, motion_d;
  logic [COUNT_WIDTH-1:0] qrc_q, qrc_d, mrc_q, mrc_d;
  logic signed [SW_EFF-1:0] now_q [3];
  logic signed [SW_EFF-1:0] now_d [3];
  logic signed [SW_EFF-1:0] last_q [3];
  logic signed [SW_EFF-1:0] last_d [3];
  logic signed [SW_EFF-1:0] ref_q [3];
  logic signed [SW_EFF-1:0] ref_d [3];
  logic              raised_q, raised_d, in_motion_q, in_motion_d;
  logic [WIDE_W-1:0] la_q, la_d, lb_q, lb_d, dot_q, dot_d, m_q, m_d;
  logic [P_W-1:0]    p_q, p_d;
  logic              zero_q, zero_d, short_q, short_d, dotle_q, dotle_d;

  logic [15:0]              axis_raw [3];
  logic signed [SW_EFF-1:0] axis_conv [3];
  logic signed [SW_EFF:0]   diff [3];
  logic [SW_EFF:0]          dabs [3], rabs [3], cabs [3];
  logic [DIG_W-1:0]         dmag [3], rmag [3], cmag [3];
  logic                     pneg [3];
  logic [15:0]              thr;
  logic                     acc_neg, acc_zero, gt_thr;
  logic [NXT_W-1:0]         mnext, qnext;

  wrgd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wrgd_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  // Sample unpacking
  assign axis_raw[0] = s_axis_tdata[16:1];
  assign axis_raw[1] = s_axis_tdata[32:17];
  assign axis_raw[2] = s_axis_tdata[48:33];

  if (SAMPLE_WIDTH > 16) begin : g_wide
    for (genvar k = 0; k < 3; k++) begin : g_ax
      assign axis_conv[k] = $signed({1'b0, axis_raw[k]});
    end
  end else begin : g_narrow
    for (genvar k = 0; k < 3; k++) begin : g_ax
      assign axis_conv[k] = $signed(axis_raw[k][SW_EFF-1:0]);
    end
  end

  // Per-axis magnitudes feeding the multiplier
  for (genvar k = 0; k < 3; k++) begin : g_mag
    assign diff[k] = $signed({now_q[k][SW_EFF-1], now_q[k]})
                   - $signed({last_q[k][SW_EFF-1], last_q[k]});
    assign dabs[k] = diff[k][SW_EFF] ? -diff[k] : diff[k];
    assign rabs[k] = ref_q[k][SW_EFF-1] ? -{ref_q[k][SW_EFF-1], ref_q[k]}
                                        : {ref_q[k][SW_EFF-1], ref_q[k]};
    assign cabs[k] = now_q[k][SW_EFF-1] ? -{now_q[k][SW_EFF-1], now_q[k]}
                                        : {now_q[k][SW_EFF-1], now_q[k]};
    assign dmag[k] = DIG_W'(dabs[k]);
    assign rmag[k] = DIG_W'(rabs[k]);
    assign cmag[k] = DIG_W'(cabs[k]);
    assign pneg[k] = ref_q[k][SW_EFF-1] ^ now_q[k][SW_EFF-1];
  end

  // Accumulator flags and counter increments
  assign thr      = motion_q ? cfg.quiet_thr : cfg.move_thr;
  assign acc_neg  = acc[ACC_W-1];
  assign acc_zero = (acc == '0);
  assign gt_thr   = !acc_neg && !acc_zero;
  assign mnext    = NXT_W'(mrc_q) + NXT_W'(1);
  assign qnext    = NXT_W'(qrc_q) + NXT_W'(1);

  // MAC step decode
  always_comb begin
    mac_op = '0;
    mac_a  = '0;
    mac_b  = '0;
    unique case (state_q)
      S_D0:  begin mac_op.en = 1'b1; mac_op.clr = 1'b1;
                   mac_a = dmag[0]; mac_b = dmag[0]; end
      S_D1:  begin mac_op.en = 1'b1; mac_a = dmag[1]; mac_b = dmag[1]; end
      S_D2:  begin mac_op.en = 1'b1; mac_a = dmag[2]; mac_b = dmag[2]; end
      S_DT:  begin mac_op.en = 1'b1; mac_op.sub = 1'b1;
                   mac_a = DIG_W'(thr); mac_b = DIG_W'(thr); end
      S_LA0: begin mac_op.en = 1'b1; mac_op.clr = 1'b1;
                   mac_a = rmag[0]; mac_b = rmag[0]; end
      S_LA1: begin mac_op.en = 1'b1; mac_a = rmag[1]; mac_b = rmag[1]; end
      S_LA2: begin mac_op.en = 1'b1; mac_a = rmag[2]; mac_b = rmag[2]; end
      S_LAM, S_LBM: begin
        mac_op.en = 1'b1; mac_op.sub = 1'b1;
        mac_a = DIG_W'(cfg.min_len); mac_b = DIG_W'(cfg.min_len);
      end
      S_LB0: begin mac_op.en = 1'b1; mac_op.clr = 1'b1;
                   mac_a = cmag[0]; mac_b = cmag[0]; end
      S_LB1: begin mac_op.en = 1'b1; mac_a = cmag[1]; mac_b = cmag[1]; end
      S_LB2: begin mac_op.en = 1'b1; mac_a = cmag[2]; mac_b = cmag[2]; end
      S_DT0: begin mac_op.en = 1'b1; mac_op.clr = 1'b1; mac_op.sub = pneg[0];
                   mac_a = rmag[0]; mac_b = cmag[0]; end
      S_DT1: begin mac_op.en = 1'b1; mac_op.sub = pneg[1];
                   mac_a = rmag[1]; mac_b = cmag[1]; end
      S_DT2: begin mac_op.en = 1'b1; mac_op.sub = pneg[2];
                   mac_a = rmag[2]; mac_b = cmag[2]; end
      S_MM:  begin mac_op.en = 1'b1; mac_op.clr = 1'b1;
                   mac_a = DIG_W'(cfg.cos_limit); mac_b = DIG_W'(cfg.cos_limit); end
      // la^2 * lb^2
      S_P00: begin mac_op.en = 1'b1; mac_op.clr = 1'b1;
                   mac_a = la_q[DIG_W-1:0]; mac_b = lb_q[DIG_W-1:0]; end
      S_P01: begin mac_op.en = 1'b1; mac_op.shift = SH_W'(DIG_W);
                   mac_a = la_q[DIG_W-1:0]; mac_b = lb_q[WIDE_W-1:DIG_W]; end
      S_P10: begin mac_op.en = 1'b1; mac_op.shift = SH_W'(DIG_W);
                   mac_a = la_q[WIDE_W-1:DIG_W]; mac_b = lb_q[DIG_W-1:0]; end
      S_P11: begin mac_op.en = 1'b1; mac_op.shift = SH_W'(2 * DIG_W);
                   mac_a = la_q[WIDE_W-1:DIG_W]; mac_b = lb_q[WIDE_W-1:DIG_W]; end
      // 2^30 * dot^2
      S_Q00: begin mac_op.en = 1'b1; mac_op.clr = 1'b1; mac_op.shift = SH_W'(TILT_SH);
                   mac_a = dot_q[DIG_W-1:0]; mac_b = dot_q[DIG_W-1:0]; end
      S_Q01, S_Q10: begin
        mac_op.en = 1'b1; mac_op.shift = SH_W'(TILT_SH + DIG_W);
        mac_a = dot_q[DIG_W-1:0]; mac_b = dot_q[WIDE_W-1:DIG_W];
      end
      S_Q11: begin mac_op.en = 1'b1; mac_op.shift = SH_W'(TILT_SH + 2 * DIG_W);
                   mac_a = dot_q[WIDE_W-1:DIG_W]; mac_b = dot_q[WIDE_W-1:DIG_W]; end
      // minus L^2 * la^2 * lb^2
      S_S00: begin mac_op.en = 1'b1; mac_op.sub = 1'b1;
                   mac_a = p_q[DIG_W-1:0]; mac_b = m_q[DIG_W-1:0]; end
      S_S01: begin mac_op.en = 1'b1; mac_op.sub = 1'b1; mac_op.shift = SH_W'(DIG_W);
                   mac_a = p_q[DIG_W-1:0]; mac_b = m_q[WIDE_W-1:DIG_W]; end
      S_S10: begin mac_op.en = 1'b1; mac_op.sub = 1'b1; mac_op.shift = SH_W'(DIG_W);
                   mac_a = p_q[2*DIG_W-1:DIG_W]; mac_b = m_q[DIG_W-1:0]; end
      S_S11: begin mac_op.en = 1'b1; mac_op.sub = 1'b1; mac_op.shift = SH_W'(2 * DIG_W);
                   mac_a = p_q[2*DIG_W-1:DIG_W]; mac_b = m_q[WIDE_W-1:DIG_W]; end
      S_S20: begin mac_op.en = 1'b1; mac_op.sub = 1'b1; mac_op.shift = SH_W'(2 * DIG_W);
                   mac_a = p_q[3*DIG_W-1:2*DIG_W]; mac_b = m_q[DIG_W-1:0]; end
      S_S21: begin mac_op.en = 1'b1; mac_op.sub = 1'b1; mac_op.shift = SH_W'(3 * DIG_W);
                   mac_a = p_q[3*DIG_W-1:2*DIG_W]; mac_b = m_q[WIDE_W-1:DIG_W]; end
      S_S30: begin mac_op.en = 1'b1; mac_op.sub = 1'b1; mac_op.shift = SH_W'(3 * DIG_W);
                   mac_a = p_q[P_W-1:3*DIG_W]; mac_b = m_q[DIG_W-1:0]; end
      S_S31: begin mac_op.en = 1'b1; mac_op.sub = 1'b1; mac_op.shift = SH_W'(4 * DIG_W);
                   mac_a = p_q[P_W-1:3*DIG_W]; mac_b = m_q[WIDE_W-1:DIG_W]; end
      default: begin
        mac_op = '0;
      end
    endcase
  end

  // Sequencer and state update
  always_comb begin
    state_d     = state_q;
    have_ref_d  = have_ref_q;
    motion_d    = motion_q;
    qrc_d       = qrc_q;
    mrc_d       = mrc_q;
    now_d       = now_q;
    last_d      = last_q;
    ref_d       = ref_q;
    raised_d    = raised_q;
    in_motion_d = in_motion_q;
    la_d        = la_q;
    lb_d        = lb_q;
    dot_d       = dot_q;
    m_d         = m_q;
    p_d         = p_q;
    zero_d      = zero_q;
    short_d     = short_q;
    dotle_d     = dotle_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          now_d    = axis_conv;
          raised_d = 1'b0;
          if (!s_axis_tdata[0]) begin
            // watching off: forget reference, end motion
            have_ref_d  = 1'b0;
            motion_d    = 1'b0;
            in_motion_d = 1'b0;
            state_d     = S_OUT;
          end else if (!have_ref_q) begin
            last_d      = axis_conv;
            ref_d       = axis_conv;
            have_ref_d  = 1'b1;
            in_motion_d = motion_q;
            state_d     = S_OUT;
          end else begin
            state_d = S_D0;
          end
        end
      end
      S_D0:  state_d = S_D1;
      S_D1:  state_d = S_D2;
      S_D2:  state_d = S_DT;
      S_DT:  state_d = S_DEC;
      S_DEC: begin
        // acc holds the squared change minus the squared threshold
        last_d  = now_q;
        state_d = S_OUT;
        if (!motion_q) begin
          if (gt_thr) begin
            motion_d    = 1'b1;
            qrc_d       = '0;
            mrc_d       = '0;
            in_motion_d = 1'b1;
          end else begin
            ref_d       = now_q;
            in_motion_d = 1'b0;
          end
        end else begin
          mrc_d = mnext[COUNT_WIDTH-1:0];
          if (mnext > NXT_W'(cfg.move_tmo)) begin
            motion_d    = 1'b0;
            ref_d       = now_q;
            in_motion_d = 1'b0;
          end else if (gt_thr) begin
            qrc_d       = '0;
            in_motion_d = 1'b1;
          end else begin
            qrc_d = qnext[COUNT_WIDTH-1:0];
            if (qnext < NXT_W'(cfg.quiet_cnt)) begin
              in_motion_d = 1'b1;
            end else begin
              // quiet run complete: test the tilt
              motion_d    = 1'b0;
              in_motion_d = 1'b0;
              state_d     = S_LA0;
            end
          end
        end
      end
      S_LA0: state_d = S_LA1;
      S_LA1: state_d = S_LA2;
      S_LA2: state_d = S_LAM;
      S_LAM: begin
        la_d    = acc[WIDE_W-1:0];
        zero_d  = acc_zero;
        state_d = S_LB0;
      end
      S_LB0: begin
        short_d = acc_neg;
        state_d = S_LB1;
      end
      S_LB1: state_d = S_LB2;
      S_LB2: state_d = S_LBM;
      S_LBM: begin
        lb_d    = acc[WIDE_W-1:0];
        zero_d  = zero_q || acc_zero;
        state_d = S_DT0;
      end
      S_DT0: begin
        short_d = short_q || acc_neg;
        state_d = S_DT1;
      end
      S_DT1: state_d = S_DT2;
      S_DT2: state_d = S_MM;
      S_MM: begin
        dot_d   = acc[WIDE_W-1:0];
        dotle_d = acc_neg || acc_zero;
        state_d = S_P00;
      end
      S_P00: begin
        m_d     = acc[WIDE_W-1:0];
        state_d = S_P01;
      end
      S_P01: state_d = S_P10;
      S_P10: state_d = S_P11;
      S_P11: state_d = S_Q00;
      S_Q00: begin
        p_d     = acc[P_W-1:0];
        state_d = S_Q01;
      end
      S_Q01: state_d = S_Q10;
      S_Q10: state_d = S_Q11;
      S_Q11: state_d = S_S00;
      S_S00: state_d = S_S01;
      S_S01: state_d = S_S10;
      S_S10: state_d = S_S11;
      S_S11: state_d = S_S20;
      S_S20: state_d = S_S21;
      S_S21: state_d = S_S30;
      S_S30: state_d = S_S31;
      S_S31: state_d = S_FIN;
      S_FIN: begin
        // raise, if neither vector is zero or short, on a right or obtuse angle or cos^2 at or below the limit
        raised_d = !zero_q && !short_q && (dotle_q || acc_neg || acc_zero);
        ref_d    = now_q;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      have_ref_q  <= 1'b0;
      motion_q    <= 1'b0;
      qrc_q       <= '0;
      mrc_q       <= '0;
      now_q       <= '{default: '0};
      last_q      <= '{default: '0};
      ref_q       <= '{default: '0};
      raised_q    <= 1'b0;
      in_motion_q <= 1'b0;
      la_q        <= '0;
      lb_q        <= '0;
      dot_q       <= '0;
      m_q         <= '0;
      p_q         <= '0;
      zero_q      <= 1'b0;
      short_q     <= 1'b0;
      dotle_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      have_ref_q  <= have_ref_d;
      motion_q    <= motion_d;
      qrc_q       <= qrc_d;
      mrc_q       <= mrc_d;
      now_q       <= now_d;
      last_q      <= last_d;
      ref_q       <= ref_d;
      raised_q    <= raised_d;
      in_motion_q <= in_motion_d;
      la_q        <= la_d;
      lb_q        <= lb_d;
      dot_q       <= dot_d;
      m_q         <= m_d;
      p_q         <= p_d;
      zero_q      <= zero_d;
      short_q     <= short_d;
      dotle_q     <= dotle_d;
    end
  end

  // Stream ports
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {{(OUT_DATA_W - 2){1'b0}}, in_motion_q, raised_q};

`ifndef SYNTH
  // A result never waits while a new request is taken
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("request accepted while a result is pending");

  // A raise always ends the motion
  a_raise_ends_motion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> !m_axis_tdata[1])
    else $error("raise reported with motion still active");

  // Watching off gives an all-zero result on the next cycle
  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !s_axis_tdata[0])
      |=> (m_axis_tvalid && m_axis_tdata == '0))
    else $error("idle sample did not give a cleared result");

  // Motion is only tracked against a reference
  a_motion_has_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    motion_q |-> have_ref_q)
    else $error("motion active without a reference");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_wrist_raise_gesture_detector_core.sv =====
// ----------------------------------------------------------------------------
// tb_wrist_raise_gesture_detector_core: self-checking bench for the detector
// Streams accelerometer requests with random stalls on both sides and checks
// each raised / in_motion result against a cycle-free model of the gesture
// tracker. Runs through several register settings, extremes included.
// ----------------------------------------------------------------------------
module tb_wrist_raise_gesture_detector_core;
  import wrgd_pkg::*;

  localparam int STALL_LIMIT   = 2000;  // cycles without any transfer
  localparam int SETTLE_CYCLES = 40;    // settle margin after the longest request
  localparam int LONG_HOLD     = 400;   // receiver back-pressure stretch
  localparam int DRAIN_AT      = 800;   // sender waits for all results here

  // Input request, packed as on s_axis_tdata (watching in bit 0)
  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic               watching;
  } accel_req_t;

  typedef struct packed {
    logic raised;
    logic in_motion;
  } gesture_out_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [ADDR_W-1:0]     paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Pending requests and predicted results
  accel_req_t   accel_req_q[$];
  gesture_out_t predicted_gesture_q[$];

  int n_queued    = 0;
  int n_mismatch  = 0;
  int idle_pct    = 0;
  int stall_cycles = 0;

  // Driver and monitor bookkeeping
  int tx_gap = 0, n_sent = 0;
  bit drain_wait = 1'b0;
  int rx_gap = 0, hold_left = 0, n_results = 0;

  // Model state
  cfg_t   cur_cfg = '{move_thr: RST_MOVE_THR, quiet_thr: RST_QUIET_THR,
                      quiet_cnt: RST_QUIET_CNT, move_tmo: RST_MOVE_TMO,
                      cos_limit: RST_COS_LIMIT, min_len: RST_MIN_LEN};
  bit         gd_have_ref = 1'b0;
  bit         gd_moving   = 1'b0;
  logic [7:0] gd_quiet_run  = '0;
  logic [7:0] gd_motion_run = '0;
  longint     gd_prev[3] = '{0, 0, 0};
  longint     gd_rest[3] = '{0, 0, 0};

  wrist_raise_gesture_detector_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(string what);
    n_mismatch++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // ---------------------------------------------------------------- model
  // Tilt test in exact wide integers: raise when cos(angle) <= L / 2^15
  function automatic bit tilt_qualifies(input longint rv[3], input longint cv[3]);
    longint la2, lb2, m2, dotp;
    logic [127:0] dm, lhs, wa, wb, wl;
    la2  = rv[0] * rv[0] + rv[1] * rv[1] + rv[2] * rv[2];
    lb2  = cv[0] * cv[0] + cv[1] * cv[1] + cv[2] * cv[2];
    m2   = longint'(cur_cfg.min_len) * longint'(cur_cfg.min_len);
    // zero or short vectors count as no tilt
    if (la2 == 0 || lb2 == 0 || la2 < m2 || lb2 < m2) return 1'b0;
    dotp = rv[0] * cv[0] + rv[1] * cv[1] + rv[2] * cv[2];
    if (dotp <= 0) return 1'b1;
    dm  = dotp;
    lhs = (dm * dm) << 30;
    wa  = la2;
    wb  = lb2;
    wl  = longint'(cur_cfg.cos_limit) * longint'(cur_cfg.cos_limit);
    return lhs <= wa * wb * wl;
  endfunction

  // Advances the gesture tracker by one request and returns its result
  function automatic gesture_out_t track_gesture(accel_req_t req);
    longint       now_v[3];
    longint       d, dist2;
    logic [8:0]   nxt;
    gesture_out_t res;
    res = '0;
    if (!req.watching) begin
      gd_have_ref = 1'b0;
      gd_moving   = 1'b0;
      return res;
    end
    now_v[0] = $signed(req.x);
    now_v[1] = $signed(req.y);
    now_v[2] = $signed(req.z);
    // first sample sets the reference
    if (!gd_have_ref) begin
      gd_prev     = now_v;
      gd_rest     = now_v;
      gd_have_ref = 1'b1;
      res.in_motion = gd_moving;
      return res;
    end
    dist2 = 0;
    for (int i = 0; i < 3; i++) begin
      d = now_v[i] - gd_prev[i];
      dist2 += d * d;
    end
    gd_prev = now_v;
    if (!gd_moving) begin
      if (dist2 > longint'(cur_cfg.move_thr) * longint'(cur_cfg.move_thr)) begin
        gd_moving     = 1'b1;
        gd_quiet_run  = '0;
        gd_motion_run = '0;
      end else begin
        gd_rest = now_v;
      end
      res.in_motion = gd_moving;
      return res;
    end
    // motion timeout restarts with a new reference
    nxt = {1'b0, gd_motion_run} + 9'd1;
    gd_motion_run = nxt[7:0];
    if (nxt > {1'b0, cur_cfg.move_tmo}) begin
      gd_moving = 1'b0;
      gd_rest   = now_v;
      return res;
    end
    if (dist2 > longint'(cur_cfg.quiet_thr) * longint'(cur_cfg.quiet_thr)) begin
      gd_quiet_run  = '0;
      res.in_motion = 1'b1;
      return res;
    end
    nxt = {1'b0, gd_quiet_run} + 9'd1;
    gd_quiet_run = nxt[7:0];
    if (nxt < {1'b0, cur_cfg.quiet_cnt}) begin
      res.in_motion = 1'b1;
      return res;
    end
    // quiet run complete: motion ends, test the tilt
    gd_moving  = 1'b0;
    res.raised = tilt_qualifies(gd_rest, now_v);
    gd_rest    = now_v;
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic shortint nudge(shortint v, int amp);
    int s;
    s = int'(v) + int'($urandom_range(2 * amp, 0)) - amp;
    if (s > 32767)  s = 32767;
    if (s < -32768) s = -32768;
    return shortint'(s);
  endfunction

  task automatic queue_sample(bit w, shortint v[3]);
    accel_req_q.push_back(accel_req_t'{z: v[2], y: v[1], x: v[0], watching: w});
    n_queued++;
  endtask

  task automatic push_near(shortint v[3], int amp, int n);
    shortint tmp[3];
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 3; i++) tmp[i] = nudge(v[i], amp);
      queue_sample(1'b1, tmp);
    end
  endtask

  task automatic pick_orientation(output shortint v[3]);
    int ax;
    case ($urandom_range(4, 0))
      0, 1: for (int i = 0; i < 3; i++) v[i] = shortint'($urandom);
      2: begin
        // roughly one g along a random axis
        for (int i = 0; i < 3; i++) v[i] = nudge(0, 3000);
        ax = $urandom_range(2, 0);
        v[ax] = $urandom_range(1, 0) ? nudge(16384, 1500) : nudge(-16384, 1500);
      end
      3: for (int i = 0; i < 3; i++) v[i] = nudge(0, 250);
      default: v = '{0, 0, 0};
    endcase
  endtask

  // Rest, jump(s), settle on a new orientation; sometimes broken or noisy
  task automatic queue_gesture();
    shortint r[3], c[3], m[3];
    int amp, n_move, n_quiet, n_stray;
    amp = cur_cfg.quiet_thr / 4;
    if ($urandom_range(5, 0) == 0) begin
      pick_orientation(m);
      queue_sample(1'b0, m);
    end
    pick_orientation(r);
    push_near(r, amp, $urandom_range(4, 1));
    if ($urandom_range(9, 0) == 0 && cur_cfg.move_tmo <= 30)
      n_move = cur_cfg.move_tmo + $urandom_range(2, 1);
    else
      n_move = $urandom_range(3, 1);
    for (int k = 0; k < n_move; k++) begin
      for (int i = 0; i < 3; i++) m[i] = shortint'($urandom);
      queue_sample(1'b1, m);
    end
    case ($urandom_range(3, 0))
      0:       pick_orientation(c);
      1:       for (int i = 0; i < 3; i++) c[i] = nudge(r[i], $urandom_range(3000, 0));
      default: for (int i = 0; i < 3; i++) c[i] = nudge(r[i], $urandom_range(20000, 500));
    endcase
    n_quiet = (cur_cfg.quiet_cnt > 24 ? 24 : int'(cur_cfg.quiet_cnt)) + $urandom_range(1, 0);
    // broken quiet run: a jump in the middle
    if ($urandom_range(7, 0) == 0) begin
      push_near(c, amp, n_quiet / 2 + 1);
      for (int i = 0; i < 3; i++) m[i] = shortint'($urandom);
      queue_sample(1'b1, m);
    end
    push_near(c, amp, n_quiet + 1);
    if ($urandom_range(5, 0) == 0) begin
      n_stray = $urandom_range(4, 1);
      for (int k = 0; k < n_stray; k++) begin
        for (int i = 0; i < 3; i++) m[i] = shortint'($urandom);
        queue_sample($urandom_range(3, 0) != 0, m);
      end
    end
  endtask

  // Edge cases at reset settings: all-ones and extreme axes, zero and short
  // references, tilt just under and over the default angle
  task automatic queue_directed();
    queue_sample(1'b0, '{-1, -1, -1});
    queue_sample(1'b1, '{-32768, 32767, 0});
    queue_sample(1'b1, '{-32768, 32767, 0});
    repeat (4) queue_sample(1'b1, '{32767, -32768, -1});
    queue_sample(1'b0, '{0, 0, 0});
    queue_sample(1'b1, '{0, 0, 0});
    repeat (4) queue_sample(1'b1, '{0, 0, 16384});
    repeat (4) queue_sample(1'b1, '{50, 0, -20});
    repeat (4) queue_sample(1'b1, '{0, 0, 16384});
    repeat (4) queue_sample(1'b1, '{0, 5000, 15600});
    repeat (4) queue_sample(1'b1, '{0, 8000, 14000});
  endtask

  // ---------------------------------------------------------------- config
  task automatic program_reg(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_MOVE_THR:  cur_cfg.move_thr  = val[15:0];
      REG_QUIET_THR: cur_cfg.quiet_thr = val[15:0];
      REG_QUIET_CNT: cur_cfg.quiet_cnt = val[7:0];
      REG_MOVE_TMO:  cur_cfg.move_tmo  = val[7:0];
      REG_COS_LIMIT: cur_cfg.cos_limit = val[14:0];
      REG_MIN_LEN:   cur_cfg.min_len   = val[15:0];
      default: ;
    endcase
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== val)
      flag_mismatch($sformatf("register %s reads %0d, wrote %0d", idx.name(), prdata, val));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_all(cfg_t c);
    program_reg(REG_MOVE_THR,  32'(c.move_thr));
    program_reg(REG_QUIET_THR, 32'(c.quiet_thr));
    program_reg(REG_QUIET_CNT, 32'(c.quiet_cnt));
    program_reg(REG_MOVE_TMO,  32'(c.move_tmo));
    program_reg(REG_COS_LIMIT, 32'(c.cos_limit));
    program_reg(REG_MIN_LEN,   32'(c.min_len));
  endtask

  // Queue a batch of gestures, then wait until every result is back
  task automatic run_phase(int n_items, int idle);
    int start;
    idle_pct = idle;
    start    = n_queued;
    while (n_queued - start < n_items) queue_gesture();
    // checked away from the rising edge so driver and monitor updates are seen
    while (accel_req_q.size() != 0 || s_axis_tvalid || predicted_gesture_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    queue_directed();
    run_phase(340, 8);
    program_all('{move_thr: 16'd1500, quiet_thr: 16'd600, quiet_cnt: 8'd2, move_tmo: 8'd6,
                  cos_limit: 15'd28378, min_len: 16'd2000});
    run_phase(340, 3);
    program_all('{move_thr: 16'd0, quiet_thr: 16'd0, quiet_cnt: 8'd0, move_tmo: 8'd0,
                  cos_limit: 15'd0, min_len: 16'd0});
    run_phase(340, 15);
    program_all('{move_thr: 16'hFFFF, quiet_thr: 16'hFFFF, quiet_cnt: 8'hFF,
                  move_tmo: 8'hFF, cos_limit: 15'h7FFF, min_len: 16'hFFFF});
    run_phase(340, 8);
    program_all('{move_thr: 16'($urandom_range(6000, 200)),
                  quiet_thr: 16'($urandom_range(2000, 100)),
                  quiet_cnt: 8'($urandom_range(6, 1)),
                  move_tmo: 8'($urandom_range(40, 4)),
                  cos_limit: 15'($urandom_range(32767, 0)),
                  min_len: 16'($urandom_range(3000, 0))});
    run_phase(340, 0);
    if (n_mismatch == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      // request taken: predict its result
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_gesture_q.push_back(track_gesture(accel_req_t'(s_axis_tdata[48:0])));
        n_sent++;
        if (n_sent == DRAIN_AT) drain_wait = 1'b1;
      end
      if (drain_wait && predicted_gesture_q.size() == 0) drain_wait = 1'b0;
      if (s_axis_tvalid && !s_axis_tready) begin
        // keep offering the same request
      end else if (drain_wait || tx_gap != 0 || accel_req_q.size() == 0) begin
        if (tx_gap != 0) tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
        tx_gap = $urandom_range(12, 1) - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, accel_req_q.pop_front()};
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i or negedge rst_ni) begin : rx_side
    gesture_out_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (predicted_gesture_q.size() == 0) begin
          flag_mismatch($sformatf("result %0d with no request pending", n_results));
        end else begin
          want = predicted_gesture_q.pop_front();
          if (m_axis_tdata[0] !== want.raised)
            flag_mismatch($sformatf("result %0d raised %b, want %b",
                                    n_results, m_axis_tdata[0], want.raised));
          if (m_axis_tdata[1] !== want.in_motion)
            flag_mismatch($sformatf("result %0d in_motion %b, want %b",
                                    n_results, m_axis_tdata[1], want.in_motion));
        end
        // long back-pressure so the input side stalls
        if (n_results == 300 || n_results == 1100) hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
        rx_gap = $urandom_range(12, 1) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
